@@ rtl/ps2mpt_pkg.sv @@
package ps2mpt_pkg;

   // Coordinate width of the cursor counters and result fields.
   localparam int COORD_BITS    = 12;
   localparam int SCREEN_BITS   = 13;
   localparam int WHEEL_BITS    = 16;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Limit after clamping to the coordinate span, and the widths of the
   // position sum and of the limit compare.
   localparam int LIM_BITS = (COORD_BITS + 1 > SCREEN_BITS) ? COORD_BITS + 1 : SCREEN_BITS;
   localparam int SUM_BITS = COORD_BITS + 2;
   localparam int CMP_BITS = (SUM_BITS > LIM_BITS) ? SUM_BITS : LIM_BITS;

   localparam logic [LIM_BITS-1:0]    COORD_SPAN     = LIM_BITS'(2 ** COORD_BITS);
   localparam logic [SCREEN_BITS-1:0] DEFAULT_WIDTH  = SCREEN_BITS'(320);
   localparam logic [SCREEN_BITS-1:0] DEFAULT_HEIGHT = SCREEN_BITS'(200);
   localparam logic [COORD_BITS-1:0]  POS_X_RESET    = COORD_BITS'(160);
   localparam logic [COORD_BITS-1:0]  POS_Y_RESET    = COORD_BITS'(100);

   // Header byte layout.
   localparam int SYNC_BIT   = 3;
   localparam int X_SIGN_BIT = 4;
   localparam int Y_SIGN_BIT = 5;
   localparam int X_OVF_BIT  = 6;
   localparam int Y_OVF_BIT  = 7;

   // Byte positions of the header and of the last byte of a packet.
   localparam logic [1:0] IDX_HEAD       = 2'd0;
   localparam logic [1:0] IDX_LAST_SHORT = 2'd2;
   localparam logic [1:0] IDX_LAST_WHEEL = 2'd3;

   typedef enum logic [1:0] {
      REG_WHEEL_MODE    = 2'd0,
      REG_SCREEN_WIDTH  = 2'd1,
      REG_SCREEN_HEIGHT = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic                   wheel_mode;
      logic [SCREEN_BITS-1:0] screen_width;
      logic [SCREEN_BITS-1:0] screen_height;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                   byte_index;
      logic [COORD_BITS-1:0]        pos_x;
      logic [COORD_BITS-1:0]        pos_y;
      logic [2:0]                   buttons;
      logic signed [WHEEL_BITS-1:0] wheel_sum;
   } track_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]        cursor_x;
      logic [COORD_BITS-1:0]        cursor_y;
      logic [2:0]                   buttons;
      logic signed [7:0]            wheel_step;
      logic signed [WHEEL_BITS-1:0] wheel_total;
      logic                         overflow_dropped;
   } result_type;

endpackage

@@ rtl/ps2mpt_packet.sv @@
module ps2mpt_packet (
   input  logic [7:0]             rx_byte,
   input  ps2mpt_pkg::cfg_type    cfg,
   input  ps2mpt_pkg::track_type  track,
   input  logic [2:0][7:0]        store,
   output logic                   store_we,
   output logic                   emit,
   output ps2mpt_pkg::track_type  track_in,
   output ps2mpt_pkg::result_type result
);
   import ps2mpt_pkg::*;

   function automatic logic [LIM_BITS-1:0] limit_of(
      input logic [SCREEN_BITS-1:0] reg_value,
      input logic [SCREEN_BITS-1:0] dflt
   );
      logic [LIM_BITS-1:0] raw;
      raw = LIM_BITS'((reg_value != '0) ? reg_value : dflt);
      return (raw > COORD_SPAN) ? COORD_SPAN : raw;
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_coord(
      input logic signed [SUM_BITS-1:0] v,
      input logic [LIM_BITS-1:0]        lim
   );
      logic [CMP_BITS-1:0] v_u;
      logic [CMP_BITS-1:0] lim_u;
      logic [LIM_BITS-1:0] top;
      v_u   = CMP_BITS'($unsigned(v));
      lim_u = CMP_BITS'(lim);
      top   = lim - LIM_BITS'(1);
      if (v[SUM_BITS-1]) begin
         return '0;
      end else if (v_u >= lim_u) begin
         return top[COORD_BITS-1:0];
      end else begin
         return v_u[COORD_BITS-1:0];
      end
   endfunction

   logic                         skip;
   logic                         complete;
   logic [7:0]                   b0;
   logic [7:0]                   b1;
   logic [7:0]                   b2;
   logic                         dropped;
   logic signed [8:0]            dx;
   logic signed [8:0]            dy;
   logic signed [SUM_BITS-1:0]   sum_x;
   logic signed [SUM_BITS-1:0]   sum_y;
   logic signed [7:0]            step;
   logic signed [WHEEL_BITS:0]   wsum;
   logic signed [WHEEL_BITS-1:0] wsat;

   // A header byte must carry the sync bit; anything else is dropped.
   assign skip     = (track.byte_index == IDX_HEAD) && !rx_byte[SYNC_BIT];
   // Mode cleared mid-packet: a fourth byte still closes a short packet.
   assign complete = !skip && (cfg.wheel_mode ? (track.byte_index == IDX_LAST_WHEEL)
                                              : (track.byte_index >= IDX_LAST_SHORT));
   assign store_we = !skip && !complete;
   assign emit     = complete;

   assign b0 = store[0];
   assign b1 = store[1];
   assign b2 = (track.byte_index == IDX_LAST_SHORT) ? rx_byte : store[2];

   assign dropped = b0[X_OVF_BIT] | b0[Y_OVF_BIT];
   assign dx      = {b0[X_SIGN_BIT], b1};
   assign dy      = {b0[Y_SIGN_BIT], b2};
   assign sum_x   = $signed({2'b00, track.pos_x}) + SUM_BITS'(dx);
   assign sum_y   = $signed({2'b00, track.pos_y}) - SUM_BITS'(dy);

   assign step = cfg.wheel_mode ? $signed(rx_byte) : 8'sd0;
   assign wsum = (WHEEL_BITS + 1)'(track.wheel_sum) + (WHEEL_BITS + 1)'(step);

   always_comb begin
      if (wsum[WHEEL_BITS] != wsum[WHEEL_BITS-1]) begin
         wsat = wsum[WHEEL_BITS] ? {1'b1, {(WHEEL_BITS - 1){1'b0}}}
                                 : {1'b0, {(WHEEL_BITS - 1){1'b1}}};
      end else begin
         wsat = wsum[WHEEL_BITS-1:0];
      end
   end

   always_comb begin
      track_in = track;
      if (store_we) begin
         track_in.byte_index = track.byte_index + 2'd1;
      end else if (complete) begin
         track_in.byte_index = IDX_HEAD;
         if (!dropped) begin
            track_in.buttons   = b0[2:0];
            track_in.pos_x     = clamp_coord(sum_x, limit_of(cfg.screen_width, DEFAULT_WIDTH));
            track_in.pos_y     = clamp_coord(sum_y, limit_of(cfg.screen_height, DEFAULT_HEIGHT));
            track_in.wheel_sum = wsat;
         end
      end
   end

   always_comb begin
      result.cursor_x         = track_in.pos_x;
      result.cursor_y         = track_in.pos_y;
      result.buttons          = track_in.buttons;
      result.wheel_step       = dropped ? 8'sd0 : step;
      result.wheel_total      = track_in.wheel_sum;
      result.overflow_dropped = dropped;
   end

endmodule

@@ rtl/ps2_mouse_packet_tracker_unit.sv @@
// Channel  Ports                 Direction  Carries
// req      req_valid/req_ready   in         one word: rx_byte from the mouse port
// rsp      rsp_valid/rsp_ready   out        one word per completed packet
// csr      APB csr_psel..pready  in/out     wheel_mode, screen_width, screen_height
//
// One input word is taken every cycle while req_ready is high; a packet's last
// byte passes through the input register, then the result register, before
// its result is valid on rsp.
// The per-byte decode and cursor/wheel update sit between those two registers.
// While a result waits on rsp_ready, one more word is held in the input
// register; a word that completes no packet still moves on during the stall.
// Reset is synchronous, active high: cursor to 160,100, wheel/buttons to zero.
module ps2_mouse_packet_tracker_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   // input words
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [7:0]                               req_rx_byte,
   // results
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [ps2mpt_pkg::COORD_BITS-1:0]        rsp_cursor_x,
   output logic [ps2mpt_pkg::COORD_BITS-1:0]        rsp_cursor_y,
   output logic                                     rsp_button_left,
   output logic                                     rsp_button_right,
   output logic                                     rsp_button_middle,
   output logic signed [7:0]                        rsp_wheel_step,
   output logic signed [ps2mpt_pkg::WHEEL_BITS-1:0] rsp_wheel_total,
   output logic                                     rsp_overflow_dropped,
   // configuration
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [ps2mpt_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [ps2mpt_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [ps2mpt_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                     csr_pready
);
   import ps2mpt_pkg::*;

   // configuration registers
   cfg_type     cfg_ff;
   logic        csr_write;
   csr_reg_type csr_sel;

   // input stage
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [7:0]  in_byte_ff;

   // tracker state
   track_type       track_ff;
   track_type       track_in;
   logic [2:0][7:0] store_ff;

   // result stage
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   result_type  rsp_ff;
   result_type  result;

   logic        store_we;
   logic        emit;
   logic        advance;

   // ---------------------------------------------------------------- CSR
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_sel)
            REG_WHEEL_MODE:    cfg_ff.wheel_mode    <= csr_pwdata[0];
            REG_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_pwdata[SCREEN_BITS-1:0];
            REG_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_pwdata[SCREEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_WHEEL_MODE:    csr_prdata = CSR_DATA_BITS'(cfg_ff.wheel_mode);
         REG_SCREEN_WIDTH:  csr_prdata = CSR_DATA_BITS'(cfg_ff.screen_width);
         REG_SCREEN_HEIGHT: csr_prdata = CSR_DATA_BITS'(cfg_ff.screen_height);
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- datapath
   ps2mpt_packet u_packet (
      .rx_byte  (in_byte_ff),
      .cfg      (cfg_ff),
      .track    (track_ff),
      .store    (store_ff),
      .store_we (store_we),
      .emit     (emit),
      .track_in (track_in),
      .result   (result)
   );

   // The held word moves on unless it closes a packet and the result
   // register is still full and not being drained.
   assign advance   = in_valid_ff && (!emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         track_ff     <= '{byte_index: IDX_HEAD, pos_x: POS_X_RESET, pos_y: POS_Y_RESET,
                           buttons: 3'b000, wheel_sum: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            track_ff <= track_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && emit) begin
         rsp_ff <= result;
      end
      // packet bytes land at their own slot as the index walks the packet
      for (int i = 0; i < 3; i++) begin
         if (advance && store_we && (track_ff.byte_index == 2'(i))) begin
            store_ff[i] <= in_byte_ff;
         end
      end
   end

   // ------------------------------------------------------------ outputs
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cursor_x         = rsp_ff.cursor_x;
   assign rsp_cursor_y         = rsp_ff.cursor_y;
   assign rsp_button_left      = rsp_ff.buttons[0];
   assign rsp_button_right     = rsp_ff.buttons[1];
   assign rsp_button_middle    = rsp_ff.buttons[2];
   assign rsp_wheel_step       = rsp_ff.wheel_step;
   assign rsp_wheel_total      = rsp_ff.wheel_total;
   assign rsp_overflow_dropped = rsp_ff.overflow_dropped;

endmodule

@@ dv/packet_result_checker.sv @@
`timescale 1ns / 1ps

module packet_result_checker
   import ps2mpt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [COORD_BITS-1:0]         rsp_cursor_x,
   input  logic [COORD_BITS-1:0]         rsp_cursor_y,
   input  logic                          rsp_button_left,
   input  logic                          rsp_button_right,
   input  logic                          rsp_button_middle,
   input  logic signed [7:0]             rsp_wheel_step,
   input  logic signed [WHEEL_BITS-1:0]  rsp_wheel_total,
   input  logic                          rsp_overflow_dropped,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]      csr_pwdata,
   input  logic                          csr_pready,
   output int                            mismatches,
   output int                            outstanding
);

   localparam int WHEEL_MAX = 2 ** (WHEEL_BITS - 1) - 1;
   localparam int WHEEL_MIN = -(2 ** (WHEEL_BITS - 1));

   cfg_type               cfg;
   logic [1:0]            byte_pos;
   logic [7:0]            held [3];
   logic [COORD_BITS-1:0] cur_x;
   logic [COORD_BITS-1:0] cur_y;
   logic [2:0]            btn;
   int                    wheel_acc;
   result_type            packet_results_q [$];

   // zero picks the default, anything past the counter span saturates
   function automatic int screen_limit(input logic [SCREEN_BITS-1:0] size, input int dflt);
      int lim;
      lim = (size == '0) ? dflt : int'(size);
      if (lim > 2 ** COORD_BITS) lim = 2 ** COORD_BITS;
      return lim;
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_coord(input int v, input int lim);
      if (v < 0) v = 0;
      if (v >= lim) v = lim - 1;
      return COORD_BITS'(v);
   endfunction

   function automatic void decode_word(input logic [7:0] b);
      logic [1:0] last;
      logic [7:0] hdr;
      logic [7:0] y_low;
      logic       dropped;
      int         step;
      result_type res;
      last = cfg.wheel_mode ? IDX_LAST_WHEEL : IDX_LAST_SHORT;
      if (byte_pos == IDX_HEAD && !b[SYNC_BIT]) return;
      if (byte_pos < last) begin
         held[byte_pos] = b;
         byte_pos = byte_pos + 2'd1;
         return;
      end
      // packet done; a stray fourth byte after wheel mode was cleared is ignored
      hdr     = held[0];
      y_low   = (byte_pos == IDX_LAST_SHORT) ? b : held[2];
      dropped = hdr[X_OVF_BIT] | hdr[Y_OVF_BIT];
      step    = 0;
      if (!dropped) begin
         btn   = hdr[2:0];
         cur_x = clamp_coord(int'(cur_x) + int'(held[1]) - (hdr[X_SIGN_BIT] ? 256 : 0),
                             screen_limit(cfg.screen_width, int'(DEFAULT_WIDTH)));
         cur_y = clamp_coord(int'(cur_y) - (int'(y_low) - (hdr[Y_SIGN_BIT] ? 256 : 0)),
                             screen_limit(cfg.screen_height, int'(DEFAULT_HEIGHT)));
         if (cfg.wheel_mode && byte_pos == IDX_LAST_WHEEL) begin
            step      = int'($signed(b));
            wheel_acc = wheel_acc + step;
            if (wheel_acc > WHEEL_MAX) wheel_acc = WHEEL_MAX;
            if (wheel_acc < WHEEL_MIN) wheel_acc = WHEEL_MIN;
         end
      end
      byte_pos             = IDX_HEAD;
      res.cursor_x         = cur_x;
      res.cursor_y         = cur_y;
      res.buttons          = btn;
      res.wheel_step       = 8'(step);
      res.wheel_total      = WHEEL_BITS'(wheel_acc);
      res.overflow_dropped = dropped;
      packet_results_q.push_back(res);
   endfunction

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         cfg        = '0;
         byte_pos   = IDX_HEAD;
         held       = '{default: '0};
         cur_x      = POS_X_RESET;
         cur_y      = POS_Y_RESET;
         btn        = '0;
         wheel_acc  = 0;
         mismatches = 0;
         packet_results_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (packet_results_q.size() == 0) begin
               $error("unexpected result: cursor_x %0d, cursor_y %0d",
                      rsp_cursor_x, rsp_cursor_y);
               mismatches++;
            end else begin
               want = packet_results_q.pop_front();
               check_field("cursor_x", int'(want.cursor_x), int'(rsp_cursor_x));
               check_field("cursor_y", int'(want.cursor_y), int'(rsp_cursor_y));
               check_field("button_left", int'(want.buttons[0]), int'(rsp_button_left));
               check_field("button_right", int'(want.buttons[1]), int'(rsp_button_right));
               check_field("button_middle", int'(want.buttons[2]), int'(rsp_button_middle));
               check_field("wheel_step", int'($signed(want.wheel_step)),
                           int'($signed(rsp_wheel_step)));
               check_field("wheel_total", int'($signed(want.wheel_total)),
                           int'($signed(rsp_wheel_total)));
               check_field("overflow_dropped", int'(want.overflow_dropped),
                           int'(rsp_overflow_dropped));
            end
         end
         if (req_valid && req_ready) decode_word(req_rx_byte);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_reg_type'(csr_paddr[CSR_ADDR_BITS-1:2]))
               REG_WHEEL_MODE:    cfg.wheel_mode    = csr_pwdata[0];
               REG_SCREEN_WIDTH:  cfg.screen_width  = csr_pwdata[SCREEN_BITS-1:0];
               REG_SCREEN_HEIGHT: cfg.screen_height = csr_pwdata[SCREEN_BITS-1:0];
               default: ;
            endcase
         end
      end
      outstanding = packet_results_q.size();
   end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import ps2mpt_pkg::*;

   localparam int ITEM_TARGET  = 1850;   // words to offer before wrapping up
   localparam int STALL_LIMIT  = 5000;   // cycles without any handshake
   localparam int HOLD_CYCLES  = 300;    // long receiver back-off
   localparam int PUSH_PACKETS = 300;    // enough +112..127 wheel steps to saturate

   // Opening words, default config (3-byte packets, 320x200, cursor 160,100):
   // a word with no sync bit (all zero), the same with every other bit set,
   // all buttons with +255 in X (clamps right), both signs with zero low
   // bytes (-256 each: X pulls back toward the left, Y clamps at the bottom),
   // X overflow, Y overflow, then two words of a packet that wheel mode will
   // stretch to four.
   localparam logic [7:0] OPENING [16] = '{
      8'h00, 8'hF7,
      8'h0F, 8'hFF, 8'h00,
      8'h38, 8'h00, 8'h00,
      8'h48, 8'h12, 8'h34,
      8'h88, 8'hFF, 8'hFF,
      8'h0A, 8'h01
   };

   // Wheel mode, huge width, height 1: finish the stretched packet with
   // +127 on the wheel, a -128 wheel packet, then three words of a packet
   // that is cut short by clearing wheel mode.
   localparam logic [7:0] WHEEL_RUN [9] = '{
      8'h02, 8'h7F,
      8'h08, 8'h00, 8'h00, 8'h80,
      8'h09, 8'h10, 8'h20
   };

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;

   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [7:0]                   req_rx_byte = '0;

   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [COORD_BITS-1:0]        rsp_cursor_x;
   logic [COORD_BITS-1:0]        rsp_cursor_y;
   logic                         rsp_button_left;
   logic                         rsp_button_right;
   logic                         rsp_button_middle;
   logic signed [7:0]            rsp_wheel_step;
   logic signed [WHEEL_BITS-1:0] rsp_wheel_total;
   logic                         rsp_overflow_dropped;

   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]     csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]     csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]     csr_prdata;
   logic                         csr_pready;

   int mismatches;
   int outstanding;     // packet results predicted but not yet seen
   int words_sent  = 0;
   int idle_cycles = 0;
   bit quiet       = 1'b0;   // sender runs without gaps this phase
   bit rsp_steady  = 1'b0;   // receiver runs without stalls for a while
   bit hold_rsp    = 1'b0;   // asks the receiver for one long back-off

   ps2_mouse_packet_tracker_unit i_dut (.*);

   packet_result_checker i_checker (.*);

   always #10 clock = ~clock;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog: any handshake or bus access counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("ps2_mouse_packet_tracker_unit regression: fail");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // One word on req; returns right after the edge that took it.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = quiet ? 0 : int'($urandom_range(0, 6));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // Let every predicted result drain, then give trailing words (those that
   // finish no packet) time to clear the input register.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      wait (outstanding == 0);
      repeat (8) @(posedge clock);
   endtask

   // APB write: setup then access; ends with the bus idle so calls can chain.
   task automatic csr_write(input csr_reg_type which, input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({which, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Screen size mix: default, one pixel, around the counter span, top code.
   function automatic logic [CSR_DATA_BITS-1:0] pick_limit();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 1;
         2:       return 4095;
         3:       return 4096;
         4:       return 4097;
         5:       return 8191;
         default: return $urandom_range(1, 8191);
      endcase
   endfunction

   // Motion delta in -256..255; a direction biases the walk toward an edge.
   function automatic int draw_delta(input int dir);
      if (dir > 0) return int'($urandom_range(0, 255));
      if (dir < 0) return -int'($urandom_range(1, 256));
      if ($urandom_range(0, 1) == 0) return int'($urandom_range(0, 16)) - 8;
      return int'($urandom_range(0, 511)) - 256;
   endfunction

   // Well-formed packet with random content. Outside the wheel push phase,
   // some packets get overflow bits, a stray word ahead of them, or are
   // cut short so the stream goes out of step.
   task automatic send_packet(input bit wheel, input int dir_x, input int dir_y,
                              input bit push);
      logic [7:0] pkt [4];
      logic [1:0] ovf;
      int         dx;
      int         dy;
      int         len;
      dx     = draw_delta(dir_x);
      dy     = draw_delta(dir_y);
      pkt[0] = 8'($urandom_range(0, 7));
      pkt[0][SYNC_BIT]   = 1'b1;
      pkt[0][X_SIGN_BIT] = (dx < 0);
      pkt[0][Y_SIGN_BIT] = (dy < 0);
      if (!push && $urandom_range(0, 7) == 0) begin
         ovf = 2'($urandom_range(1, 3));
         pkt[0][X_OVF_BIT] = ovf[0];
         pkt[0][Y_OVF_BIT] = ovf[1];
      end
      pkt[1] = dx[7:0];
      pkt[2] = dy[7:0];
      pkt[3] = push ? 8'($urandom_range(112, 127)) : 8'($urandom());
      len    = wheel ? 4 : 3;
      if (!push && $urandom_range(0, 11) == 0) send_byte(8'($urandom()));
      if (!push && $urandom_range(0, 15) == 0) len = int'($urandom_range(1, len - 1));
      for (int i = 0; i < len; i++) send_byte(pkt[i]);
   endtask

   // Receiver: random stall per result, stall-free stretches, and one long
   // back-off so the block fills and pushes back on req.
   initial begin : rsp_drive
      int wait_cycles;
      bit hold_done;
      hold_done = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 31) == 0) rsp_steady = !rsp_steady;
         wait_cycles = rsp_steady ? 0 : int'($urandom_range(0, 6));
         if (hold_rsp && !hold_done) begin
            hold_done   = 1'b1;
            wait_cycles = HOLD_CYCLES;
         end
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      int phase;
      int dir_x;
      int dir_y;
      int packets;
      bit wheel;
      bit push;
      wait (reset == 1'b0);
      @(posedge clock);

      // directed opening
      foreach (OPENING[i]) send_byte(OPENING[i]);
      drain();
      csr_write(REG_WHEEL_MODE, 1);
      csr_write(REG_SCREEN_WIDTH, 8191);
      csr_write(REG_SCREEN_HEIGHT, 1);
      foreach (WHEEL_RUN[i]) send_byte(WHEEL_RUN[i]);
      drain();
      // wheel mode off with three words held: the fourth word closes the
      // packet as a 3-byte one and is otherwise ignored
      csr_write(REG_WHEEL_MODE, 0);
      send_byte(8'hAA);
      drain();

      // Random phases, each under a fresh config. Phases may end mid-packet,
      // so config changes also land inside packets. Phase 1 asks for the
      // long receiver hold; phase 3 drives the wheel total into saturation
      // and the cursor against the right edge of the widest screen.
      phase = 0;
      while (words_sent < ITEM_TARGET) begin
         push  = (phase == 3);
         wheel = push || ($urandom_range(0, 1) == 1);
         csr_write(REG_WHEEL_MODE, CSR_DATA_BITS'(wheel));
         csr_write(REG_SCREEN_WIDTH, push ? 8191 : pick_limit());
         csr_write(REG_SCREEN_HEIGHT, pick_limit());
         quiet = ($urandom_range(0, 3) == 0);
         if (phase == 1) hold_rsp = 1'b1;
         dir_x   = push ? 1 : int'($urandom_range(0, 2)) - 1;
         dir_y   = int'($urandom_range(0, 2)) - 1;
         packets = push ? PUSH_PACKETS : int'($urandom_range(10, 30));
         repeat (packets) send_packet(wheel, dir_x, dir_y, push);
         drain();
         phase++;
      end

      if (mismatches == 0)
         $display("ps2_mouse_packet_tracker_unit regression: pass");
      else
         $display("ps2_mouse_packet_tracker_unit regression: fail");
      $finish;
   end

endmodule

@@ ps2_mouse_packet_tracker_unit.f @@
rtl/ps2mpt_pkg.sv
rtl/ps2mpt_packet.sv
rtl/ps2_mouse_packet_tracker_unit.sv
dv/packet_result_checker.sv
dv/testbench.sv
